[src/cfe_pkg.sv]
`default_nettype none

package cfe_pkg;

  localparam logic [2:0] CMD_SET_CHAR = 3'd0;
  localparam logic [2:0] CMD_SET_ATTR = 3'd1;
  localparam logic [2:0] CMD_SET_FG   = 3'd2;
  localparam logic [2:0] CMD_SET_BG   = 3'd3;
  localparam logic [2:0] CMD_FILL     = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;
  localparam logic [2:0] CMD_READ     = 3'd6;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RESET  = 8'd80;
  localparam logic [6:0] HEIGHT_RESET = 7'd25;

  localparam logic [15:0] FG_KEEP_MASK = 16'h00F0;
  localparam logic [15:0] BG_KEEP_MASK = 16'h000F;

  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

[src/cfe_if.sv]
`default_nettype none

interface cfe_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic signed [8:0] pos_x;
  logic signed [7:0] pos_y;
  logic signed [8:0] rect_width;
  logic signed [7:0] rect_height;
  logic [7:0]        char_code;
  logic [15:0]       attrib_word;
  logic [3:0]        color_nibble;

  modport source (
    output valid, cmd, pos_x, pos_y, rect_width, rect_height,
           char_code, attrib_word, color_nibble,
    input  ready
  );
  modport sink (
    input  valid, cmd, pos_x, pos_y, rect_width, rect_height,
           char_code, attrib_word, color_nibble,
    output ready
  );
endinterface

interface cfe_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [15:0] cell_attrib;
  logic        in_range;

  modport source (
    output valid, cell_char, cell_attrib, in_range,
    input  ready
  );
  modport sink (
    input  valid, cell_char, cell_attrib, in_range,
    output ready
  );
endinterface

`default_nettype wire

[src/cfe_ram.sv]
`default_nettype none

module cfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/cfe_queue.sv]
`default_nettype none

module cfe_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == NW'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/cfe_front.sv]
`default_nettype none

module cfe_front #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  localparam int AW = $clog2(MAX_COLS * MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int WW = $clog2(MAX_COLS + 1),
  localparam int HW = $clog2(MAX_ROWS + 1),
  localparam int EW = 3 + 1 + AW + CW + RW + WW + 8 + 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  cfe_req_if.sink            req,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          hold,
  output logic               push_valid,
  input  wire logic          push_ready,
  output logic      [EW-1:0] push_data
);

  import cfe_pkg::*;

  typedef struct packed {
    logic [2:0]    op;
    logic          hit;
    logic [AW-1:0] addr;
    logic [CW-1:0] ncols;
    logic [RW-1:0] nrows;
    logic [WW-1:0] stride;
    logic [7:0]    char_code;
    logic [15:0]   attr;
  } entry_t;

  typedef struct packed {
    logic               ok;
    logic signed [11:0] lo;
    logic signed [11:0] hi;
  } span_t;

  function automatic span_t span(input logic signed [11:0] p,
                                 input logic signed [11:0] len,
                                 input logic signed [11:0] lim);
    logic signed [11:0] a;
    logic signed [11:0] b;
    span_t              s;
    if (len > 12'sd0) begin
      a = p;
      b = p + len - 12'sd1;
    end else begin
      a = p + len;
      b = p - 12'sd1;
    end
    if (a < 12'sd0) begin
      a = 12'sd0;
    end
    if (b > lim - 12'sd1) begin
      b = lim - 12'sd1;
    end
    s.ok = (len != 12'sd0) && (a <= b);
    s.lo = a;
    s.hi = b;
    return s;
  endfunction

  logic [7:0]         buffer_width;
  logic [6:0]         buffer_height;
  logic [WW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic signed [11:0] px, py, lx, ly, lim_x, lim_y;
  span_t              xs, ys;
  logic               take;
  logic               advance;

  logic               b_valid;
  logic [2:0]         b_op;
  logic               b_hit;
  logic [CW-1:0]      b_x0;
  logic [RW-1:0]      b_y0;
  logic [CW-1:0]      b_ncols;
  logic [RW-1:0]      b_nrows;
  logic [WW-1:0]      b_stride;
  logic [7:0]         b_char;
  logic [15:0]        b_attr;
  logic [RW+WW-1:0]   row_off;
  entry_t             entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_width  <= WIDTH_RESET;
      buffer_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  buffer_width  <= cfg_data;
        CFG_IDX_HEIGHT: buffer_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (buffer_width == 8'd0) begin
      eff_w = WW'(1);
    end else if ({1'b0, buffer_width} > 9'(MAX_COLS)) begin
      eff_w = WW'(MAX_COLS);
    end else begin
      eff_w = WW'(buffer_width);
    end
    if (buffer_height == 7'd0) begin
      eff_h = HW'(1);
    end else if ({2'b0, buffer_height} > 9'(MAX_ROWS)) begin
      eff_h = HW'(MAX_ROWS);
    end else begin
      eff_h = HW'(buffer_height);
    end
  end

  always_comb begin
    px    = {{3{req.pos_x[8]}}, req.pos_x};
    py    = {{4{req.pos_y[7]}}, req.pos_y};
    lim_x = $signed(12'(eff_w));
    lim_y = $signed(12'(eff_h));
    if (req.cmd == CMD_FILL) begin
      lx = {{3{req.rect_width[8]}}, req.rect_width};
      ly = {{4{req.rect_height[7]}}, req.rect_height};
    end else begin
      lx = 12'sd1;
      ly = 12'sd1;
    end
    xs = span(px, lx, lim_x);
    ys = span(py, ly, lim_y);
  end

  assign advance   = !b_valid || push_ready;
  assign req.ready = !hold && advance;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= take && (req.cmd <= CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_op     <= req.cmd;
      b_stride <= eff_w;
      b_char   <= req.char_code;
      if (req.cmd == CMD_SET_FG || req.cmd == CMD_SET_BG) begin
        b_attr <= {12'd0, req.color_nibble};
      end else begin
        b_attr <= req.attrib_word;
      end
      if (req.cmd == CMD_CLEAR) begin
        b_hit   <= 1'b1;
        b_x0    <= '0;
        b_y0    <= '0;
        b_ncols <= CW'(eff_w - WW'(1));
        b_nrows <= RW'(eff_h - HW'(1));
      end else begin
        b_hit   <= xs.ok && ys.ok;
        b_x0    <= xs.lo[CW-1:0];
        b_y0    <= ys.lo[RW-1:0];
        b_ncols <= CW'(xs.hi - xs.lo);
        b_nrows <= RW'(ys.hi - ys.lo);
      end
    end
  end

  assign row_off = (RW+WW)'(b_y0) * (RW+WW)'(b_stride);

  always_comb begin
    entry.op        = b_op;
    entry.hit       = b_hit;
    entry.addr      = AW'(row_off) + AW'(b_x0);
    entry.ncols     = b_ncols;
    entry.nrows     = b_nrows;
    entry.stride    = b_stride;
    entry.char_code = b_char;
    entry.attr      = b_attr;
  end

  assign push_valid = b_valid;
  assign push_data  = entry;

endmodule

`default_nettype wire

[src/cfe_back.sv]
`default_nettype none

module cfe_back #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  localparam int CELLS = MAX_COLS * MAX_ROWS,
  localparam int AW = $clog2(CELLS),
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int WW = $clog2(MAX_COLS + 1),
  localparam int EW = 3 + 1 + AW + CW + RW + WW + 8 + 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [EW-1:0] head_data,
  input  wire logic          empty,
  output logic               pop,
  output logic               clearing,
  cfe_rsp_if.source          rsp
);

  import cfe_pkg::*;

  typedef struct packed {
    logic [2:0]    op;
    logic          hit;
    logic [AW-1:0] addr;
    logic [CW-1:0] ncols;
    logic [RW-1:0] nrows;
    logic [WW-1:0] stride;
    logic [7:0]    char_code;
    logic [15:0]   attr;
  } entry_t;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_NIB   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  entry_t        head;
  logic [2:0]    state;
  logic [AW-1:0] walk_addr;
  logic [AW-1:0] row_base;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] ncols;
  logic [RW-1:0] nrows;
  logic [WW-1:0] stride;
  logic [2:0]    op_hold;
  logic [7:0]    char_hold;
  logic [15:0]   attr_hold;

  logic          out_valid;
  logic          out_load;
  logic [7:0]    out_char;
  logic [15:0]   out_attr;
  logic          out_in_range;

  logic          c_we, a_we;
  logic [AW-1:0] waddr;
  logic [7:0]    c_wd, c_rd;
  logic [15:0]   a_wd, a_rd;
  logic [15:0]   nib_merged;

  assign head     = head_data;
  assign clearing = (state == ST_CLEAR);

  cfe_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (waddr),
    .wdata (c_wd),
    .raddr (head.addr),
    .rdata (c_rd)
  );

  cfe_ram #(.WIDTH(16), .DEPTH(CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (a_wd),
    .raddr (head.addr),
    .rdata (a_rd)
  );

  always_comb begin
    if (op_hold == CMD_SET_FG) begin
      nib_merged = (a_rd & FG_KEEP_MASK) | {12'd0, attr_hold[3:0]};
    end else begin
      nib_merged = (a_rd & BG_KEEP_MASK) | {8'd0, attr_hold[3:0], 4'd0};
    end
  end

  always_comb begin
    pop   = 1'b0;
    c_we  = 1'b0;
    a_we  = 1'b0;
    waddr = walk_addr;
    c_wd  = char_hold;
    a_wd  = attr_hold;
    unique case (state)
      ST_CLEAR: begin
        c_we = 1'b1;
        a_we = 1'b1;
        c_wd = '0;
        a_wd = '0;
      end
      ST_IDLE: begin
        if (!empty) begin
          waddr = head.addr;
          unique case (head.op) inside
            CMD_SET_CHAR: begin
              pop  = 1'b1;
              c_we = head.hit;
              c_wd = head.char_code;
            end
            CMD_SET_ATTR: begin
              pop  = 1'b1;
              a_we = head.hit;
              a_wd = head.attr;
            end
            CMD_READ: pop = !out_valid || rsp.ready;
            default:  pop = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        c_we = 1'b1;
        a_we = 1'b1;
      end
      ST_NIB: begin
        a_we = 1'b1;
        a_wd = nib_merged;
      end
      ST_READ: ;
      default: ;
    endcase
  end

  assign out_load = (state == ST_READ) ||
                    ((state == ST_IDLE) && pop && (head.op == CMD_READ) && !head.hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      walk_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          walk_addr <= walk_addr + 1'b1;
          if (walk_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            op_hold   <= head.op;
            char_hold <= head.char_code;
            attr_hold <= head.attr;
            walk_addr <= head.addr;
            row_base  <= head.addr;
            col       <= '0;
            row       <= '0;
            ncols     <= head.ncols;
            nrows     <= head.nrows;
            stride    <= head.stride;
            unique case (head.op) inside
              CMD_SET_FG, CMD_SET_BG: begin
                if (head.hit) begin
                  state <= ST_NIB;
                end
              end
              CMD_FILL, CMD_CLEAR: begin
                if (head.hit) begin
                  state <= ST_WALK;
                end
              end
              CMD_READ: begin
                if (head.hit) begin
                  state <= ST_READ;
                end else begin
                  out_char     <= '0;
                  out_attr     <= '0;
                  out_in_range <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (col == ncols) begin
            if (row == nrows) begin
              state <= ST_IDLE;
            end else begin
              row       <= row + 1'b1;
              col       <= '0;
              row_base  <= row_base + AW'(stride);
              walk_addr <= row_base + AW'(stride);
            end
          end else begin
            col       <= col + 1'b1;
            walk_addr <= walk_addr + 1'b1;
          end
        end
        ST_NIB: state <= ST_IDLE;
        ST_READ: begin
          out_char     <= c_rd;
          out_attr     <= a_rd;
          out_in_range <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.cell_char   = out_char;
  assign rsp.cell_attrib = out_attr;
  assign rsp.in_range    = out_in_range;

endmodule

`default_nettype wire

[src/character_cell_fill_engine_top.sv]
`default_nettype none
// channel   dir  handshake      payload
// req       in   valid/ready    cmd pos_x pos_y rect_width rect_height char_code
//                               attrib_word color_nibble
// rsp       out  valid/ready    cell_char cell_attrib in_range
// cfg       in   cfg_we         cfg_index cfg_data (no back-pressure)
//
// After reset the store is zeroed, one cell a cycle over all MAX_COLS*MAX_ROWS cells
// (8192 by default) with req.ready low. A command then passes a one-stage
// registered decode into a 4-entry queue; the executor behind it does a character
// or attribute write straight from idle, a nibble write or an in-range read through
// its NIB or READ state, and a fill or clear by walking the covered cells one cell a cycle
// over the store's single write port. Reads wait while the result register is full and not being taken.

module character_cell_fill_engine_top #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  cfe_req_if.sink         req,
  cfe_rsp_if.source       rsp,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  import cfe_pkg::*;

  localparam int AW = $clog2(MAX_COLS * MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int WW = $clog2(MAX_COLS + 1);
  localparam int EW = 3 + 1 + AW + CW + RW + WW + 8 + 16;

  logic          push_valid;
  logic          q_full;
  logic [EW-1:0] push_data;
  logic [EW-1:0] head_data;
  logic          q_empty;
  logic          pop;
  logic          clearing;

  cfe_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .hold       (clearing),
    .push_valid (push_valid),
    .push_ready (!q_full),
    .push_data  (push_data)
  );

  cfe_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head_data (head_data),
    .empty     (q_empty)
  );

  cfe_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_data (head_data),
    .empty     (q_empty),
    .pop       (pop),
    .clearing  (clearing),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[bench/character_cell_fill_engine_top_tb.sv]
`default_nettype none

module character_cell_fill_engine_top_tb;
  import cfe_pkg::*;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int N_SHAPES = 8;
  localparam int ITEMS_PER_SHAPE = 150;

  typedef struct packed {
    logic [2:0]        cmd;
    logic signed [8:0] pos_x;
    logic signed [7:0] pos_y;
    logic signed [8:0] rect_width;
    logic signed [7:0] rect_height;
    logic [7:0]        char_code;
    logic [15:0]       attrib_word;
    logic [3:0]        color_nibble;
  } screen_cmd_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [15:0] cell_attrib;
    logic        in_range;
  } cell_view_t;

  typedef struct {
    screen_cmd_t c;
    bit          typed;
    cell_view_t  want;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  cfe_req_if req_ch ();
  cfe_rsp_if rsp_ch ();

  character_cell_fill_engine_top #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [7:0]  shadow_chr [CELL_COUNT];
  logic [15:0] shadow_attr [CELL_COUNT];
  logic [7:0]  width_reg;
  logic [6:0]  height_reg;
  cell_view_t  pending_reads [$];
  dir_row_t    directed_rows [$];

  bit hold_request;
  bit no_gaps;
  int sent_count;
  int reads_checked;
  int error_count;
  int cfg_writes;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

  function automatic int cols_in_use();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic int rows_in_use();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  // signed start and extent to an inclusive range clipped to 0..lim-1
  function automatic bit clip_span(input int p, input int len, input int lim,
                                   output int lo, output int hi);
    int a;
    int b;
    lo = 0;
    hi = -1;
    if (len == 0) return 1'b0;
    if (len > 0) begin
      a = p;
      b = p + len - 1;
    end else begin
      a = p + len;
      b = p - 1;
    end
    if (a < 0) a = 0;
    if (b > lim - 1) b = lim - 1;
    if (a > b) return 1'b0;
    lo = a;
    hi = b;
    return 1'b1;
  endfunction

  function automatic bit shadow_step(input screen_cmd_t c, output cell_view_t v);
    int x, y, cols, rows, addr;
    int x0, x1, y0, y1, i, j, k;
    bit hit_x, hit_y;
    x = $signed(c.pos_x);
    y = $signed(c.pos_y);
    cols = cols_in_use();
    rows = rows_in_use();
    addr = (x >= 0 && y >= 0 && x < cols && y < rows) ? x + y * cols : -1;
    v = '0;
    case (c.cmd)
      CMD_SET_CHAR: if (addr >= 0) shadow_chr[addr] = c.char_code;
      CMD_SET_ATTR: if (addr >= 0) shadow_attr[addr] = c.attrib_word;
      CMD_SET_FG: begin
        if (addr >= 0)
          shadow_attr[addr] = {12'h000, c.color_nibble} | (shadow_attr[addr] & FG_KEEP_MASK);
      end
      CMD_SET_BG: begin
        if (addr >= 0)
          shadow_attr[addr] = {8'h00, c.color_nibble, 4'h0} |
                              (shadow_attr[addr] & BG_KEEP_MASK);
      end
      CMD_FILL: begin
        hit_x = clip_span(x, $signed(c.rect_width), cols, x0, x1);
        hit_y = clip_span(y, $signed(c.rect_height), rows, y0, y1);
        if (hit_x && hit_y) begin
          for (j = y0; j <= y1; j++) begin
            for (i = x0; i <= x1; i++) begin
              shadow_chr[i + j * cols] = c.char_code;
              shadow_attr[i + j * cols] = c.attrib_word;
            end
          end
        end
      end
      CMD_CLEAR: begin
        for (k = 0; k < cols * rows; k++) begin
          shadow_chr[k] = c.char_code;
          shadow_attr[k] = c.attrib_word;
        end
      end
      CMD_READ: begin
        if (addr >= 0) v = '{shadow_chr[addr], shadow_attr[addr], 1'b1};
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_coord(input int lim, input int full_lo, input int full_hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 7);
    if (r < 8) return $urandom_range(0, lim - 1);
    if (r == 8) begin
      r = $urandom_range(0, 2);
      return (r == 0) ? -1 : ((r == 1) ? lim - 1 : lim);
    end
    return int'($urandom_range(0, full_hi - full_lo)) + full_lo;
  endfunction

  function automatic screen_cmd_t random_command();
    screen_cmd_t c;
    int r, x, y, w, h;
    r = $urandom_range(0, 99);
    if (r < 12) c.cmd = CMD_SET_CHAR;
    else if (r < 24) c.cmd = CMD_SET_ATTR;
    else if (r < 32) c.cmd = CMD_SET_FG;
    else if (r < 40) c.cmd = CMD_SET_BG;
    else if (r < 58) c.cmd = CMD_FILL;
    else if (r < 60) c.cmd = CMD_CLEAR;
    else if (r < 63) c.cmd = CMD_UNUSED;
    else c.cmd = CMD_READ;
    x = pick_coord(cols_in_use(), -256, 255);
    y = pick_coord(rows_in_use(), -128, 127);
    if ($urandom_range(0, 9) != 0) begin
      w = int'($urandom_range(0, 12)) - 6;
      h = int'($urandom_range(0, 8)) - 4;
    end else begin
      w = int'($urandom_range(0, 256)) - 128;
      h = int'($urandom_range(0, 128)) - 64;
    end
    c.pos_x = x[8:0];
    c.pos_y = y[7:0];
    c.rect_width = w[8:0];
    c.rect_height = h[7:0];
    c.char_code = 8'($urandom);
    c.attrib_word = 16'($urandom);
    c.color_nibble = 4'($urandom);
    return c;
  endfunction

  function automatic dir_row_t mk(input logic [2:0] cmd, input int x, input int y,
                                  input int w, input int h, input logic [7:0] ch,
                                  input logic [15:0] at, input logic [3:0] nib,
                                  input bit typed, input logic [7:0] wch,
                                  input logic [15:0] wat, input logic wir);
    dir_row_t r;
    r.c = '{cmd, x[8:0], y[7:0], w[8:0], h[7:0], ch, at, nib};
    r.typed = typed;
    r.want = '{wch, wat, wir};
    return r;
  endfunction

  task automatic send_command(input screen_cmd_t c, input bit typed, input cell_view_t want);
    int gap;
    cell_view_t v;
    gap = (no_gaps || (sent_count % 160) < 40) ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.cmd = c.cmd;
    req_ch.pos_x = c.pos_x;
    req_ch.pos_y = c.pos_y;
    req_ch.rect_width = c.rect_width;
    req_ch.rect_height = c.rect_height;
    req_ch.char_code = c.char_code;
    req_ch.attrib_word = c.attrib_word;
    req_ch.color_nibble = c.color_nibble;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    if (shadow_step(c, v)) pending_reads.push_back(typed ? want : v);
    sent_count++;
  endtask

  // in-order executor: once a trailing read returns, all earlier work is done
  task automatic drain_store();
    screen_cmd_t c;
    cell_view_t none;
    c = '0;
    c.cmd = CMD_READ;
    none = '0;
    send_command(c, 1'b0, none);
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    if (idx == CFG_IDX_WIDTH) width_reg = d;
    else height_reg = d[6:0];
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side
  initial begin
    int stall;
    int results_seen;
    cell_view_t got;
    cell_view_t want;
    results_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = ((results_seen % 96) < 24) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      results_seen++;
      got = '{rsp_ch.cell_char, rsp_ch.cell_attrib, rsp_ch.in_range};
      if (pending_reads.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected transfer: char=%h attr=%h in_range=%b",
                   got.cell_char, got.cell_attrib, got.in_range);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (got !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("read %0d: exp char=%h attr=%h in_range=%b, got char=%h attr=%h in_range=%b",
                     reads_checked, want.cell_char, want.cell_attrib, want.in_range,
                     got.cell_char, got.cell_attrib, got.in_range);
        end
      end
    end
  end

  initial begin
    int p, n, k;
    screen_cmd_t c;
    cell_view_t none;
    logic [7:0] shape_w [N_SHAPES];
    logic [7:0] shape_h [N_SHAPES];
    shape_w = '{8'd80, 8'd1, 8'd128, 8'd0, 8'd255, 8'd13, 8'd200, 8'd37};
    shape_h = '{8'd25, 8'd1, 8'd64, 8'd0, 8'hFF, 8'd7, 8'd100, 8'd64};
    none = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_IDX_WIDTH;
    cfg_data = 8'd0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_SET_CHAR;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.rect_width = '0;
    req_ch.rect_height = '0;
    req_ch.char_code = '0;
    req_ch.attrib_word = '0;
    req_ch.color_nibble = '0;
    hold_request = 1'b0;
    no_gaps = 1'b0;
    sent_count = 0;
    reads_checked = 0;
    error_count = 0;
    cfg_writes = 0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    for (k = 0; k < CELL_COUNT; k++) begin
      shadow_chr[k] = '0;
      shadow_attr[k] = '0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 80 x 25 after reset
    directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 1));
    directed_rows.push_back(mk(CMD_READ, 79, 24, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 1));
    directed_rows.push_back(mk(CMD_READ, 80, 0, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 0));
    directed_rows.push_back(mk(CMD_READ, -1, 0, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 0));
    directed_rows.push_back(mk(CMD_READ, 0, 25, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 0));
    directed_rows.push_back(mk(CMD_READ, -256, -128, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 0));
    directed_rows.push_back(mk(CMD_READ, 255, 127, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 0));
    directed_rows.push_back(mk(CMD_SET_CHAR, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_SET_ATTR, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 8'hFF, 16'hFFFF, 1));
    directed_rows.push_back(mk(CMD_SET_FG, 0, 0, 0, 0, 0, 0, 4'hA, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 8'hFF, 16'h00FA, 1));
    directed_rows.push_back(mk(CMD_SET_BG, 0, 0, 0, 0, 0, 0, 4'h3, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 8'hFF, 16'h003A, 1));
    directed_rows.push_back(mk(CMD_SET_CHAR, -1, -1, 0, 0, 8'hEE, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_FILL, 10, 5, -3, -2, 8'h41, 16'h1234, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_READ, 7, 3, 0, 0, 0, 0, 0, 1, 8'h41, 16'h1234, 1));
    directed_rows.push_back(mk(CMD_READ, 10, 5, 0, 0, 0, 0, 0, 1, 8'h00, 16'h0000, 1));
    directed_rows.push_back(mk(CMD_FILL, 78, 23, 128, 64, 8'h55, 16'hAAAA, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_READ, 79, 24, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_FILL, 0, 0, 0, 5, 8'h99, 16'h9999, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_UNUSED, 3, 3, 5, 5, 8'h77, 16'h7777, 4'h7, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_FILL, 100, 30, -128, -64, 8'hC3, 16'h8001, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_READ, 40, 12, 0, 0, 0, 0, 0, 1, 8'hC3, 16'h8001, 1));
    directed_rows.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 8'h20, 16'h0700, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 8'h20, 16'h0700, 1));

    foreach (directed_rows[k])
      send_command(directed_rows[k].c, directed_rows[k].typed, directed_rows[k].want);

    for (p = 0; p < N_SHAPES; p++) begin
      if (p > 0) begin
        drain_store();
        write_reg(CFG_IDX_WIDTH, shape_w[p]);
        write_reg(CFG_IDX_HEIGHT, shape_h[p]);
      end
      if (p == 0) begin
        // result side holds off while reads keep coming
        hold_request = 1'b1;
        no_gaps = 1'b1;
        repeat (40) begin
          c = random_command();
          c.cmd = CMD_READ;
          send_command(c, 1'b0, none);
        end
        no_gaps = 1'b0;
      end
      n = 0;
      while (n < ITEMS_PER_SHAPE) begin
        c = random_command();
        send_command(c, 1'b0, none);
        if (c.cmd != CMD_UNUSED) n++;
      end
    end
    drain_store();

    $display("covered %0d commands and %0d checked reads over %0d buffer shapes (%0d reg writes)",
             sent_count, reads_checked, N_SHAPES, cfg_writes);
    $display("shapes ran from 1x1 to 128x64 with saturated registers and a long result hold-off");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
